// File: rtl/core/lss_pkg.sv
// lss_pkg: shared types, codes and defaults for the LIFO store with search.
// No dependencies; imported by lss_ctrl, lss_dp, the core top and lss_chk.
`timescale 1ns / 1ps

package lss_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 6;

  localparam logic [2:0] MODE_PUSH     = 3'd0;
  localparam logic [2:0] MODE_POP      = 3'd1;
  localparam logic [2:0] MODE_DUMP_NEW = 3'd2;
  localparam logic [2:0] MODE_DUMP_OLD = 3'd3;
  localparam logic [2:0] MODE_SEARCH   = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic single;
    logic rd;
    logic emit;
    logic step;
    logic pop;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] mode;
    logic       empty;
    logic       out_free;
    logic       hit;
    logic       at_end;
  } sts_t;

endpackage

// File: rtl/core/lss_ram.sv
// lss_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lss_ctrl.sv
// lss_ctrl: operation sequencer for the LIFO store.
// Depends on lss_pkg; drives lss_dp through cmd_t, observes sts_t.
`timescale 1ns / 1ps

module lss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lss_pkg::sts_t sts,
  output lss_pkg::cmd_t cmd
);
  import lss_pkg::*;

  state_t state_r, state_nxt;
  logic   mode_ok, is_push, is_pop, is_search, single_op, walk_done;

  assign mode_ok   = sts.mode <= MODE_SEARCH;
  assign is_push   = sts.mode == MODE_PUSH;
  assign is_pop    = sts.mode == MODE_POP;
  assign is_search = sts.mode == MODE_SEARCH;
  assign single_op = is_push || sts.empty;
  assign walk_done = is_pop || sts.at_end || (is_search && sts.hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!mode_ok) begin
          state_nxt = S_IDLE;
        end else if (single_op) begin
          if (sts.out_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = walk_done ? S_IDLE : S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_DECIDE: begin
        cmd.single = mode_ok && single_op && sts.out_free;
      end
      S_READ: begin
        cmd.rd = 1'b1;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = !is_search || sts.hit || sts.at_end;
          cmd.pop  = is_pop;
          cmd.step = !walk_done;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/lss_dp.sv
// lss_dp: entry RAM, entry count, walk index and output register.
// Depends on lss_pkg and lss_ram; commanded by lss_ctrl.
`timescale 1ns / 1ps

module lss_dp #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lss_pkg::cmd_t cmd,
  output lss_pkg::sts_t sts,
  input  lss_pkg::in_t  in_data,
  input  logic          out_stall,
  output logic          out_valid,
  output lss_pkg::out_t out_data
);
  import lss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  in_t              item_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             full, empty, hit, at_end, out_free, push_ok;
  logic [CW-1:0]    top_idx;
  logic [PW-1:0]    pos_ext;
  logic [AW-1:0]    raddr;
  logic [DATA_W-1:0] rd_data;

  assign full     = cnt_r == CW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign push_ok  = item_r.mode == MODE_PUSH && !full;
  assign top_idx  = cnt_r - CW'(1) - idx_r;
  assign raddr    = (item_r.mode == MODE_DUMP_OLD) ? idx_r[AW-1:0] : top_idx[AW-1:0];
  assign hit      = rd_data == $unsigned(item_r.value);
  assign at_end   = (idx_r + CW'(1)) == cnt_r;
  assign pos_ext  = PW'(idx_r) + PW'(1);
  assign out_free = !out_valid_r || !out_stall;

  lss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.single && push_ok),
    .waddr (cnt_r[AW-1:0]),
    .wdata (item_r.value),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.single && push_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end

    idx_nxt = idx_r;
    if (cmd.accept) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + CW'(1);
    end

    out_nxt      = out_r;
    out_nxt.last = 1'b1;
    if (cmd.single) begin
      out_nxt.data     = '0;
      out_nxt.position = '0;
      if (item_r.mode == MODE_PUSH) begin
        out_nxt.status = full ? STAT_FULL : STAT_OK;
      end else begin
        out_nxt.status = STAT_EMPTY;
      end
    end else if (cmd.emit) begin
      if (item_r.mode == MODE_SEARCH) begin
        out_nxt.status   = hit ? STAT_OK : STAT_MISS;
        out_nxt.data     = '0;
        out_nxt.position = hit ? pos_ext[POS_W-1:0] : '0;
      end else begin
        out_nxt.status   = STAT_OK;
        out_nxt.data     = $signed(rd_data);
        out_nxt.position = '0;
        out_nxt.last     = (item_r.mode == MODE_POP) || at_end;
      end
    end

    out_valid_nxt = out_valid_r;
    if (cmd.single || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    idx_r <= idx_nxt;
    if (cmd.single || cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign sts.mode     = item_r.mode;
  assign sts.empty    = empty;
  assign sts.out_free = out_free;
  assign sts.hit      = hit;
  assign sts.at_end   = at_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/lifo_store_with_search_core.sv
// lifo_store_with_search_core: top level of the bounded LIFO store with search.
// Depends on lss_pkg, lss_ctrl, lss_dp (and lss_ram through lss_dp).
//
//   channel | ports                          | carries
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | in_t: mode, value
//   output  | out_valid, out_stall, out_data | out_t: status, data, pos, last
//
// One transaction is taken at a time; in_stall is high until the last result
// is loaded into the output register.
// Push, pop, and any empty or full case give a single result. Dumps and
// search walk the entry RAM one entry at a time (registered read, then emit
// or compare). Output stalls hold the walk in place.
// Synchronous active-low reset clears the entry count and the output valid.
`timescale 1ns / 1ps

module lifo_store_with_search_core #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lss_pkg::out_t out_data
);
  import lss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/lss_chk.sv
// lss_chk: port-level checks for lifo_store_with_search_core, bound to it.
// Depends on lss_pkg.
`timescale 1ns / 1ps

module lss_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input lss_pkg::out_t out_data
);
  import lss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in progress");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.last)
    else $error("non-ok status on a result that is not last");

  a_hit_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.position != '0 |->
      out_data.status == STAT_OK && out_data.data == '0 && out_data.last)
    else $error("search hit result malformed");

endmodule

bind lifo_store_with_search_core lss_chk u_chk (.*);
